[rtl/tqt_pkg.sv]
// shared constants for the task queue with timer table
package tqt_pkg;

  // request codes
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_POP  = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  // default sizes
  localparam int READY_SLOTS_DEF  = 16;
  localparam int TIMER_SLOTS_DEF  = 8;
  localparam int TASK_ID_BITS_DEF = 8;
  localparam int DELAY_BITS_DEF   = 32;

  // tick report counters
  localparam int               CNT_W   = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

[rtl/task_queue_with_timer_table_core.sv]
// top level: ready fifo and timer table under one slot-walking sequencer
//
//  channel  ports                                         handshake
//  -------  --------------------------------------------  -------------------------
//  request  in_mode, in_task_id, in_delay                 beat when start & !busy
//  result   out_dispatched_task, out_dispatch_valid,      beat when out_strobe,
//           out_accepted, out_expired_count,              one cycle, no backpressure
//           out_dropped_count
//
//  enqueue and dispatch hold busy high in one state (S_ENQ or S_POP) after the beat.
//  set and tick walk the timer slots through one registered table read port:
//  each slot visited passes through S_RD, and each occupied one also through S_CHK;
//  a set that does not hit an existing entry ends in S_INS.
//  out_strobe is high for one cycle, the first cycle with busy low; the receiver cannot stall.
//  rst_n is synchronous; reset empties the fifo and frees every timer slot.
module task_queue_with_timer_table_core
  import tqt_pkg::*;
#(
  parameter int READY_SLOTS  = READY_SLOTS_DEF,
  parameter int TIMER_SLOTS  = TIMER_SLOTS_DEF,
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF,
  parameter int DELAY_BITS   = DELAY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_mode,
  input  logic [TASK_ID_BITS-1:0] in_task_id,
  input  logic [DELAY_BITS-1:0]   in_delay,
  output logic                    out_strobe,
  output logic [TASK_ID_BITS-1:0] out_dispatched_task,
  output logic                    out_dispatch_valid,
  output logic                    out_accepted,
  output logic [CNT_W-1:0]        out_expired_count,
  output logic [CNT_W-1:0]        out_dropped_count
);

  localparam int PTR_W  = $clog2(READY_SLOTS);
  localparam int RC_W   = $clog2(READY_SLOTS + 1);
  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_ENQ, S_POP, S_RD, S_CHK, S_INS} state_t;

  // memories
  logic [TASK_ID_BITS-1:0] fifo_mem [READY_SLOTS];
  logic [TASK_ID_BITS-1:0] tmr_task_mem [TIMER_SLOTS];
  logic [DELAY_BITS-1:0]   tmr_rem_mem [TIMER_SLOTS];
  logic [TASK_ID_BITS-1:0] fifo_q;
  logic [TASK_ID_BITS-1:0] tmr_task_q;
  logic [DELAY_BITS-1:0]   tmr_rem_q;

  // write ports
  logic                    fw_en;
  logic [TASK_ID_BITS-1:0] fw_data;
  logic                    tw_en;
  logic [SLOT_W-1:0]       tw_addr;
  logic [TASK_ID_BITS-1:0] tw_task;
  logic [DELAY_BITS-1:0]   tw_rem;

  // control state
  state_t                  state_r, state_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic [TASK_ID_BITS-1:0] id_r, id_nxt;
  logic [DELAY_BITS-1:0]   dly_r, dly_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [TIMER_SLOTS-1:0]  vld_r, vld_nxt;
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic [RC_W-1:0]         count_r, count_nxt;
  logic                    found_r, found_nxt;
  logic [SLOT_W-1:0]       free_r, free_nxt;
  logic [CNT_W-1:0]        exp_r, exp_nxt;
  logic [CNT_W-1:0]        drop_r, drop_nxt;

  // result registers
  logic                    out_strobe_r, out_strobe_nxt;
  logic [TASK_ID_BITS-1:0] out_task_r, out_task_nxt;
  logic                    out_dv_r, out_dv_nxt;
  logic                    out_acc_r, out_acc_nxt;
  logic [CNT_W-1:0]        out_exp_r, out_exp_nxt;
  logic [CNT_W-1:0]        out_drop_r, out_drop_nxt;

  // finishing values
  logic                    fin;
  logic [TASK_ID_BITS-1:0] fin_task;
  logic                    fin_dv;
  logic                    fin_acc;
  logic [CNT_W-1:0]        fin_exp;
  logic [CNT_W-1:0]        fin_drop;

  logic                    fifo_full;
  logic                    last_slot;
  logic [PTR_W-1:0]        head_inc;
  logic [PTR_W-1:0]        tail_inc;
  logic [SLOT_W-1:0]       slot_inc;

  assign fifo_full = (count_r == RC_W'(READY_SLOTS));
  assign last_slot = (slot_r == SLOT_W'(TIMER_SLOTS - 1));
  assign head_inc  = (head_r == PTR_W'(READY_SLOTS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == PTR_W'(READY_SLOTS - 1)) ? '0 : tail_r + 1'b1;
  assign slot_inc  = slot_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    dly_nxt        = dly_r;
    slot_nxt       = slot_r;
    vld_nxt        = vld_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    free_nxt       = free_r;
    exp_nxt        = exp_r;
    drop_nxt       = drop_r;
    out_strobe_nxt = 1'b0;
    out_task_nxt   = out_task_r;
    out_dv_nxt     = out_dv_r;
    out_acc_nxt    = out_acc_r;
    out_exp_nxt    = out_exp_r;
    out_drop_nxt   = out_drop_r;
    fw_en          = 1'b0;
    fw_data        = tmr_task_q;
    tw_en          = 1'b0;
    tw_addr        = slot_r;
    tw_task        = tmr_task_q;
    tw_rem         = tmr_rem_q;
    fin            = 1'b0;
    fin_task       = '0;
    fin_dv         = 1'b0;
    fin_acc        = 1'b0;
    fin_exp        = '0;
    fin_drop       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          id_nxt    = in_task_id;
          dly_nxt   = in_delay;
          slot_nxt  = '0;
          found_nxt = 1'b0;
          free_nxt  = '0;
          exp_nxt   = '0;
          drop_nxt  = '0;
          unique case (in_mode)
            MODE_ENQ: state_nxt = S_ENQ;
            // idle id never enters the table: straight to a refused insert
            MODE_SET: state_nxt = (in_task_id == '0) ? S_INS : S_RD;
            MODE_POP: state_nxt = S_POP;
            default:  state_nxt = S_RD;
          endcase
        end
      end

      S_ENQ: begin
        fin = 1'b1;
        if (id_r != '0 && !fifo_full) begin
          fw_en     = 1'b1;
          fw_data   = id_r;
          tail_nxt  = tail_inc;
          count_nxt = count_r + 1'b1;
          fin_acc   = 1'b1;
        end
      end

      S_POP: begin
        fin = 1'b1;
        if (count_r != '0) begin
          fin_task  = fifo_q;
          fin_dv    = (fifo_q != '0);
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
      end

      S_RD: begin
        if (vld_r[slot_r]) begin
          state_nxt = S_CHK;
        end else begin
          if (mode_r == MODE_SET && !found_r) begin
            found_nxt = 1'b1;
            free_nxt  = slot_r;
          end
          if (!last_slot) begin
            slot_nxt = slot_inc;
          end else if (mode_r == MODE_SET) begin
            state_nxt = S_INS;
          end else begin
            fin      = 1'b1;
            fin_exp  = exp_r;
            fin_drop = drop_r;
          end
        end
      end

      S_CHK: begin
        if (mode_r == MODE_TICK) begin
          if (tmr_rem_q > DELAY_BITS'(1)) begin
            tw_en  = 1'b1;
            tw_rem = tmr_rem_q - 1'b1;
          end else begin
            // expire: free the slot and hand the task to the fifo, or count a drop if it is full
            vld_nxt[slot_r] = 1'b0;
            if (exp_r != CNT_MAX) exp_nxt = exp_r + 1'b1;
            if (!fifo_full) begin
              fw_en     = 1'b1;
              tail_nxt  = tail_inc;
              count_nxt = count_r + 1'b1;
            end else if (drop_r != CNT_MAX) begin
              drop_nxt = drop_r + 1'b1;
            end
          end
          if (last_slot) begin
            fin      = 1'b1;
            fin_exp  = exp_nxt;
            fin_drop = drop_nxt;
          end else begin
            slot_nxt  = slot_inc;
            state_nxt = S_RD;
          end
        end else begin
          if (tmr_task_q == id_r) begin
            tw_en   = 1'b1;
            tw_task = id_r;
            tw_rem  = dly_r;
            fin     = 1'b1;
            fin_acc = 1'b1;
          end else if (last_slot) begin
            state_nxt = S_INS;
          end else begin
            slot_nxt  = slot_inc;
            state_nxt = S_RD;
          end
        end
      end

      S_INS: begin
        fin = 1'b1;
        if (found_r) begin
          tw_en           = 1'b1;
          tw_addr         = free_r;
          tw_task         = id_r;
          tw_rem          = dly_r;
          vld_nxt[free_r] = 1'b1;
          fin_acc         = 1'b1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      state_nxt      = S_IDLE;
      out_strobe_nxt = 1'b1;
      out_task_nxt   = fin_task;
      out_dv_nxt     = fin_dv;
      out_acc_nxt    = fin_acc;
      out_exp_nxt    = fin_exp;
      out_drop_nxt   = fin_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    mode_r     <= mode_nxt;
    id_r       <= id_nxt;
    dly_r      <= dly_nxt;
    slot_r     <= slot_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    exp_r      <= exp_nxt;
    drop_r     <= drop_nxt;
    out_task_r <= out_task_nxt;
    out_dv_r   <= out_dv_nxt;
    out_acc_r  <= out_acc_nxt;
    out_exp_r  <= out_exp_nxt;
    out_drop_r <= out_drop_nxt;
  end

  // ready fifo: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (fw_en) fifo_mem[tail_r] <= fw_data;
    fifo_q <= fifo_mem[head_r];
  end

  // timer table: one write port, registered read at the walking slot
  always_ff @(posedge clk) begin
    if (tw_en) begin
      tmr_task_mem[tw_addr] <= tw_task;
      tmr_rem_mem[tw_addr]  <= tw_rem;
    end
    tmr_task_q <= tmr_task_mem[slot_r];
    tmr_rem_q  <= tmr_rem_mem[slot_r];
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = out_strobe_r;
  assign out_dispatched_task = out_task_r;
  assign out_dispatch_valid  = out_dv_r;
  assign out_accepted        = out_acc_r;
  assign out_expired_count   = out_exp_r;
  assign out_dropped_count   = out_drop_r;

endmodule

[tb/task_queue_with_timer_table_checker.sv]
// scheduler checker: predicts each request's report and compares it with the strobed result
`timescale 1ns / 1ps

module task_queue_with_timer_table_checker
  import tqt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [TASK_ID_BITS_DEF-1:0] in_task_id,
  input  logic [DELAY_BITS_DEF-1:0]   in_delay,
  input  logic                        out_strobe,
  input  logic [TASK_ID_BITS_DEF-1:0] out_dispatched_task,
  input  logic                        out_dispatch_valid,
  input  logic                        out_accepted,
  input  logic [CNT_W-1:0]            out_expired_count,
  input  logic [CNT_W-1:0]            out_dropped_count,
  output int                          fail_count,
  output int                          pending
);

  localparam int ID_W  = TASK_ID_BITS_DEF;
  localparam int DLY_W = DELAY_BITS_DEF;

  typedef struct packed {
    logic [ID_W-1:0]  disp_id;
    logic             disp_ok;
    logic             acc;
    logic [CNT_W-1:0] n_expired;
    logic [CNT_W-1:0] n_dropped;
  } sched_report_t;

  // scheduler state as the block should hold it
  logic [ID_W-1:0]  ready_ids[$];
  logic [ID_W-1:0]  timer_id  [TIMER_SLOTS_DEF];
  logic [DLY_W-1:0] timer_left[TIMER_SLOTS_DEF];

  sched_report_t report_q[$];
  sched_report_t want;

  function automatic void clear_schedule();
    int i;
    ready_ids.delete();
    for (i = 0; i < TIMER_SLOTS_DEF; i++) begin
      timer_id[i]   = '0;
      timer_left[i] = '0;
    end
  endfunction

  function automatic sched_report_t apply_request(logic [1:0] mode, logic [ID_W-1:0] id,
                                                  logic [DLY_W-1:0] dly);
    sched_report_t r;
    int i;
    int slot;
    r = '0;
    case (mode)
      MODE_ENQ: begin
        if (id != 0 && ready_ids.size() < READY_SLOTS_DEF) begin
          ready_ids.push_back(id);
          r.acc = 1'b1;
        end
      end
      MODE_SET: begin
        if (id != 0) begin
          slot = -1;
          // an armed task is re-armed in place before any free slot is taken
          for (i = 0; i < TIMER_SLOTS_DEF; i++)
            if (slot < 0 && timer_id[i] == id) slot = i;
          for (i = 0; i < TIMER_SLOTS_DEF; i++)
            if (slot < 0 && timer_id[i] == 0) begin
              slot = i;
              timer_id[i] = id;
            end
          if (slot >= 0) begin
            timer_left[slot] = dly;
            r.acc = 1'b1;
          end
        end
      end
      MODE_POP: begin
        if (ready_ids.size() != 0) begin
          r.disp_id = ready_ids.pop_front();
          r.disp_ok = (r.disp_id != 0);
        end
      end
      default: begin
        for (i = 0; i < TIMER_SLOTS_DEF; i++) begin
          if (timer_id[i] != 0) begin
            if (timer_left[i] > 1) begin
              timer_left[i] = timer_left[i] - 1'b1;
            end else begin
              if (r.n_expired != CNT_MAX) r.n_expired = r.n_expired + 1'b1;
              if (ready_ids.size() < READY_SLOTS_DEF) ready_ids.push_back(timer_id[i]);
              else if (r.n_dropped != CNT_MAX) r.n_dropped = r.n_dropped + 1'b1;
              timer_id[i] = '0;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_schedule();
      report_q.delete();
    end else begin
      // a result beat can share an edge with the next request beat: compare first
      if (out_strobe) begin
        if (report_q.size() == 0) begin
          $display("%0t: result beat with no request outstanding, actual task %0d", $time,
                   out_dispatched_task);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("dispatched_task", 32'(want.disp_id),   32'(out_dispatched_task));
          check_field("dispatch_valid",  32'(want.disp_ok),   32'(out_dispatch_valid));
          check_field("accepted",        32'(want.acc),       32'(out_accepted));
          check_field("expired_count",   32'(want.n_expired), 32'(out_expired_count));
          check_field("dropped_count",   32'(want.n_dropped), 32'(out_dropped_count));
        end
      end
      if (start && !busy) report_q.push_back(apply_request(in_mode, in_task_id, in_delay));
    end
    pending = report_q.size();
  end

endmodule

[tb/task_queue_with_timer_table_core_tb.sv]
// testbench top: request stimulus, watchdog and verdict for the task scheduler core
`timescale 1ns / 1ps

module task_queue_with_timer_table_core_tb;
  import tqt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 50;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  in_mode = MODE_ENQ;
  logic [TASK_ID_BITS_DEF-1:0] in_task_id = '0;
  logic [DELAY_BITS_DEF-1:0]   in_delay = '0;
  logic                        out_strobe;
  logic [TASK_ID_BITS_DEF-1:0] out_dispatched_task;
  logic                        out_dispatch_valid;
  logic                        out_accepted;
  logic [CNT_W-1:0]            out_expired_count;
  logic [CNT_W-1:0]            out_dropped_count;
  int                          fail_count;
  int                          pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task_queue_with_timer_table_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_task_id          (in_task_id),
    .in_delay            (in_delay),
    .out_strobe          (out_strobe),
    .out_dispatched_task (out_dispatched_task),
    .out_dispatch_valid  (out_dispatch_valid),
    .out_accepted        (out_accepted),
    .out_expired_count   (out_expired_count),
    .out_dropped_count   (out_dropped_count)
  );

  task_queue_with_timer_table_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_task_id          (in_task_id),
    .in_delay            (in_delay),
    .out_strobe          (out_strobe),
    .out_dispatched_task (out_dispatched_task),
    .out_dispatch_valid  (out_dispatch_valid),
    .out_accepted        (out_accepted),
    .out_expired_count   (out_expired_count),
    .out_dropped_count   (out_dropped_count),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // one request beat, then maybe a burst of idle cycles
  task automatic issue(input logic [1:0] mode, input logic [TASK_ID_BITS_DEF-1:0] id,
                       input logic [DELAY_BITS_DEF-1:0] dly, input bit may_idle);
    start      <= 1'b1;
    in_mode    <= mode;
    in_task_id <= id;
    in_delay   <= dly;
    do @(posedge clk); while (busy);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // hold requests off until every outstanding report has come back
  task automatic drain_reports();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [1:0] pick_mode(int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      0:       return (r < 50) ? MODE_ENQ : (r < 70) ? MODE_SET : (r < 80) ? MODE_POP : MODE_TICK;
      1:       return (r < 10) ? MODE_ENQ : (r < 50) ? MODE_SET : (r < 60) ? MODE_POP : MODE_TICK;
      2:       return (r < 15) ? MODE_ENQ : (r < 30) ? MODE_SET : (r < 85) ? MODE_POP : MODE_TICK;
      default: return r[1:0];
    endcase
  endfunction

  // watchdog: cycles with neither a request beat nor a result beat
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && !((start && !busy) || out_strobe)) idle_cycles++;
      else idle_cycles = 0;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int k;
    int r;
    logic [1:0]                  m;
    logic [TASK_ID_BITS_DEF-1:0] id;
    logic [DELAY_BITS_DEF-1:0]   dly;
    bit                          idle_on;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and idle cases, duplicates, re-arming, full table, expiry
    issue(MODE_POP,  8'd0,   32'hFFFF_FFFF, 1'b1);
    issue(MODE_ENQ,  8'd0,   32'd0,         1'b1);
    issue(MODE_ENQ,  8'd255, 32'd0,         1'b0);
    issue(MODE_ENQ,  8'd1,   32'd0,         1'b0);
    issue(MODE_ENQ,  8'd255, 32'd0,         1'b1);
    repeat (4) issue(MODE_POP, 8'd0, 32'd0, 1'b0);
    issue(MODE_SET,  8'd0,   32'd5,         1'b1);
    issue(MODE_SET,  8'd5,   32'd0,         1'b0);
    issue(MODE_SET,  8'd6,   32'd1,         1'b0);
    issue(MODE_SET,  8'd7,   32'hFFFF_FFFF, 1'b1);
    issue(MODE_SET,  8'd5,   32'd3,         1'b0);
    for (k = 8; k <= 12; k++) issue(MODE_SET, k[7:0], 32'd2, 1'b1);
    issue(MODE_SET,  8'd13,  32'd1,         1'b0);
    issue(MODE_TICK, 8'd0,   32'd0,         1'b1);
    issue(MODE_TICK, 8'd0,   32'd0,         1'b0);
    issue(MODE_SET,  8'd7,   32'd0,         1'b0);
    issue(MODE_TICK, 8'hFF,  32'hFFFF_FFFF, 1'b1);
    drain_reports();

    // random phases: fill the queue, tick into it, drain it, then a mix
    for (p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (k = 0; k < PHASE_LEN; k++) begin
        m   = pick_mode(p % 4);
        id  = TASK_ID_BITS_DEF'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
                                                              : $urandom_range(0, 255));
        dly = $urandom;
        if (m == MODE_SET) begin
          r = $urandom_range(0, 99);
          if (r < 4) dly = 32'hFFFF_FFFF;
          else if (r >= 10) dly = $urandom_range(0, 6);
        end
        issue(m, id, dly, idle_on);
      end
      drain_reports();
    end

    start <= 1'b0;
    repeat (2 * TIMER_SLOTS_DEF + 8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
